@@ sv/tppa_pkg.sv @@
`default_nettype none

package tppa_pkg;

   // field and register widths
   localparam int ADDR_W   = 48;
   localparam int PSIZE_W  = 17;
   localparam int PPA_W    = 7;
   localparam int STRIDE_W = 32;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 48;

   // widest bitmap a pool can hold
   localparam int BITMAP_MAX = 64;

   // parameter defaults
   localparam int NUM_POOLS_DEF = 32;
   localparam int MAX_PAGES_DEF = 64;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PSIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PPA    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE = 2'd3;

   // register reset values
   localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
   localparam logic [PSIZE_W-1:0]  PSIZE_RST  = 17'd64;
   localparam logic [PPA_W-1:0]    PPA_RST    = 7'd64;
   localparam logic [STRIDE_W-1:0] STRIDE_RST = 32'd65536;

endpackage

`default_nettype wire

@@ sv/tppa_req_if.sv @@
`default_nettype none

interface tppa_req_if;
   import tppa_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output operation, output address, input ready);
   modport sink   (input valid, input operation, input address, output ready);
endinterface

`default_nettype wire

@@ sv/tppa_rsp_if.sv @@
`default_nettype none

interface tppa_rsp_if;
   import tppa_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] page_address;
   logic [STAT_W-1:0] status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink   (input valid, input page_address, input status, output ready);
endinterface

`default_nettype wire

@@ sv/tppa_divider.sv @@
`default_nettype none

module tppa_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tppa_pkg::ADDR_W-1:0]   dividend,
   input  wire logic [tppa_pkg::STRIDE_W-1:0] divisor,
   output logic                               busy,
   output logic                               done,
   output logic [tppa_pkg::ADDR_W-1:0]        quotient,
   output logic [tppa_pkg::STRIDE_W-1:0]      remainder
);
   import tppa_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W + 1);

   logic [ADDR_W-1:0]   quo_ff, quo_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;
   logic [STRIDE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STRIDE_W:0]   trial;
   logic [STRIDE_W:0]   diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(ADDR_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[STRIDE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[STRIDE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ sv/two_level_page_pool_allocator_unit.sv @@
// Page allocator over NUM_POOLS pools of up to 64 fixed-size pages each.
// req_ch carries one word per request: operation (allocate or free) and the
// address to free. rsp_ch returns one word per request: page_address and status
// (ok, out of memory, invalid free). The csr_ port writes base_address,
// page_size, pages_per_array and array_stride; the user must write them only
// while the block is idle, which the block itself does not enforce. Pool bitmaps
// live in one synchronous memory (one read, one write per cycle); active bits
// are flip-flops and double as the bitmaps' valid bits. Allocate: reads the
// bitmap of each active pool in turn until one has a free page, else activates
// an idle pool (out of memory if none is idle), then marks the page, forms the
// address and loads the output register. Free: two passes through the shared
// bit-serial divider (pool then page) plus a read-modify-write. Out of memory
// on a zero page count and a free below base skip the scan and the divider. The
// next request is taken once its result has entered the output register; if the
// receiver stalls the next result holds in the block and no further request is
// taken. Reset clears all pools to inactive, loads the register defaults and
// empties the output register; no clearing pass is needed.
`default_nettype none

module two_level_page_pool_allocator_unit #(
   parameter int NUM_POOLS = tppa_pkg::NUM_POOLS_DEF,
   parameter int MAX_PAGES = tppa_pkg::MAX_PAGES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tppa_req_if.sink                             req_ch,
   tppa_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_write_enable,
   input  wire logic [tppa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tppa_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import tppa_pkg::*;

   localparam int PW   = (MAX_PAGES < BITMAP_MAX) ? MAX_PAGES : BITMAP_MAX;
   localparam int IW   = (PW > 1) ? $clog2(PW) : 1;
   localparam int PIW  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int PPW  = PIW + STRIDE_W;
   localparam int PGW  = IW + PSIZE_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CHK = 4'd2;
   localparam logic [3:0] S_ACTIVATE = 4'd3;
   localparam logic [3:0] S_MARK     = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_ADD      = 4'd6;
   localparam logic [3:0] S_DIV_POOL = 4'd7;
   localparam logic [3:0] S_DIV_PAGE = 4'd8;
   localparam logic [3:0] S_FREE_RD  = 4'd9;
   localparam logic [3:0] S_FREE_CHK = 4'd10;
   localparam logic [3:0] S_RESP     = 4'd11;

   typedef struct packed {
      logic           found;
      logic [PIW-1:0] idx;
   } pick_type;

   // lowest set bit of vec at or above from
   function automatic pick_type pick_from(input logic [NUM_POOLS-1:0] vec,
                                          input logic [PIW:0] from);
      pick_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = NUM_POOLS - 1; i >= 0; i--) begin
         if (vec[i] && ((PIW + 1)'(i) >= from)) begin
            r.found = 1'b1;
            r.idx   = PIW'(i);
         end
      end
      return r;
   endfunction

   // config registers
   logic [ADDR_W-1:0]   base_ff;
   logic [PSIZE_W-1:0]  psize_ff;
   logic [PPA_W-1:0]    ppa_ff;
   logic [STRIDE_W-1:0] stride_ff;

   // control and datapath registers
   logic [3:0]           state_ff, state_in;
   logic [NUM_POOLS-1:0] active_ff, active_in;
   logic [PIW-1:0]       pool_ff, pool_in;
   logic [IW-1:0]        page_ff, page_in;
   logic [PW-1:0]        bmp_ff, bmp_in;
   logic [PW-1:0]        lm_ff, lm_in;
   logic [PPW-1:0]       prodp_ff, prodp_in;
   logic [PGW-1:0]       prodg_ff, prodg_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [STAT_W-1:0]    res_st_ff, res_st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0]    rsp_st_ff, rsp_st_in;

   // bitmap memory
   logic [PW-1:0] bmp_mem [NUM_POOLS];
   logic [PW-1:0] mem_rd_ff;
   logic          mem_we;
   logic [PW-1:0] mem_wd;

   // divider hookup
   logic                div_start;
   logic [ADDR_W-1:0]   div_dividend;
   logic [STRIDE_W-1:0] div_divisor;
   logic                div_busy;
   logic                div_done;
   logic [ADDR_W-1:0]   div_quo;
   logic [STRIDE_W-1:0] div_rem;

   // helpers
   logic [STRIDE_W-1:0] stride_eff;
   logic [PSIZE_W-1:0]  psize_eff;
   logic [PPA_W-1:0]    lim;
   logic [PW-1:0]       lm_calc;
   logic [PW-1:0]       free_bits;
   logic [IW-1:0]       low_free;
   logic [PW-1:0]       page_bit;
   logic [PW-1:0]       cleared;
   logic                req_fire;
   pick_type            first_act;
   pick_type            next_act;
   pick_type            first_idle;

   assign stride_eff = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
   assign psize_eff  = (psize_ff == '0) ? PSIZE_W'(1) : psize_ff;
   assign lim        = (ppa_ff > PPA_W'(PW)) ? PPA_W'(PW) : ppa_ff;

   // page limit mask
   always_comb begin
      for (int i = 0; i < PW; i++) begin
         lm_calc[i] = (PPA_W'(i) < lim);
      end
   end

   // lowest free page of the chosen pool
   assign free_bits = ~bmp_ff & lm_ff;
   always_comb begin
      low_free = '0;
      for (int i = PW - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            low_free = IW'(i);
         end
      end
   end

   assign page_bit   = PW'(1) << page_ff;
   assign cleared    = mem_rd_ff & ~page_bit;
   assign first_act  = pick_from(active_ff, '0);
   assign next_act   = pick_from(active_ff, (PIW + 1)'(pool_ff) + 1'b1);
   assign first_idle = pick_from(~active_ff, '0);
   assign req_fire   = req_ch.valid && req_ch.ready;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RST;
         psize_ff  <= PSIZE_RST;
         ppa_ff    <= PPA_RST;
         stride_ff <= STRIDE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE:   base_ff   <= csr_write_data[ADDR_W-1:0];
            CSR_PSIZE:  psize_ff  <= csr_write_data[PSIZE_W-1:0];
            CSR_PPA:    ppa_ff    <= csr_write_data[PPA_W-1:0];
            CSR_STRIDE: stride_ff <= csr_write_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      pool_in      = pool_ff;
      page_in      = page_ff;
      bmp_in       = bmp_ff;
      lm_in        = lm_ff;
      prodp_in     = prodp_ff;
      prodg_in     = prodg_ff;
      res_addr_in  = res_addr_ff;
      res_st_in    = res_st_ff;
      mem_we       = 1'b0;
      mem_wd       = '0;
      div_start    = 1'b0;
      div_dividend = req_ch.address - base_ff;
      div_divisor  = stride_eff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_addr_in = '0;
               lm_in       = lm_calc;
               if (req_ch.operation == OP_ALLOC) begin
                  if (lim == '0) begin
                     res_st_in = ST_OOM;
                     state_in  = S_RESP;
                  end else if (first_act.found) begin
                     pool_in  = first_act.idx;
                     state_in = S_SCAN_RD;
                  end else begin
                     state_in = S_ACTIVATE;
                  end
               end else if (req_ch.address < base_ff) begin
                  res_st_in = ST_BADFREE;
                  state_in  = S_RESP;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV_POOL;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if ((~mem_rd_ff & lm_ff) != '0) begin
               bmp_in   = mem_rd_ff;
               state_in = S_MARK;
            end else if (next_act.found) begin
               pool_in  = next_act.idx;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_ACTIVATE;
            end
         end
         S_ACTIVATE: begin
            if (first_idle.found) begin
               pool_in              = first_idle.idx;
               active_in[first_idle.idx] = 1'b1;
               bmp_in               = '0;
               state_in             = S_MARK;
            end else begin
               res_st_in = ST_OOM;
               state_in  = S_RESP;
            end
         end
         S_MARK: begin
            mem_we   = 1'b1;
            mem_wd   = bmp_ff | (PW'(1) << low_free);
            page_in  = low_free;
            state_in = S_MUL;
         end
         S_MUL: begin
            prodp_in = PPW'(pool_ff) * PPW'(stride_eff);
            prodg_in = PGW'(page_ff) * PGW'(psize_eff);
            state_in = S_ADD;
         end
         S_ADD: begin
            res_addr_in = base_ff + ADDR_W'(prodp_ff) + ADDR_W'(prodg_ff);
            res_st_in   = ST_OK;
            state_in    = S_RESP;
         end
         S_DIV_POOL: begin
            div_dividend = ADDR_W'(div_rem);
            div_divisor  = STRIDE_W'(psize_eff);
            if (div_done) begin
               if (div_quo >= ADDR_W'(NUM_POOLS)) begin
                  res_st_in = ST_BADFREE;
                  state_in  = S_RESP;
               end else begin
                  pool_in   = div_quo[PIW-1:0];
                  div_start = 1'b1;
                  state_in  = S_DIV_PAGE;
               end
            end
         end
         S_DIV_PAGE: begin
            if (div_done) begin
               if (div_quo >= ADDR_W'(PW) || !active_ff[pool_ff]) begin
                  res_st_in = ST_BADFREE;
                  state_in  = S_RESP;
               end else begin
                  page_in  = div_quo[IW-1:0];
                  state_in = S_FREE_RD;
               end
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!mem_rd_ff[page_ff]) begin
               res_st_in = ST_BADFREE;
            end else begin
               mem_we    = 1'b1;
               mem_wd    = cleared;
               res_st_in = ST_OK;
               if (cleared == '0) begin
                  active_in[pool_ff] = 1'b0;
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_st_in    = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      pool_ff     <= pool_in;
      page_ff     <= page_in;
      bmp_ff      <= bmp_in;
      lm_ff       <= lm_in;
      prodp_ff    <= prodp_in;
      prodg_ff    <= prodg_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bmp_mem[pool_ff] <= mem_wd;
      end
      mem_rd_ff <= bmp_mem[pool_ff];
   end

   tppa_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.page_address = rsp_addr_ff;
   assign rsp_ch.status       = rsp_st_ff;

   // checks
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_mem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_MARK || state_ff == S_FREE_CHK))
      else $error("bitmap write outside mark or free");

   a_mark_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> active_ff[pool_ff])
      else $error("page marked in an inactive pool");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_POOL || state_ff == S_DIV_PAGE) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");

endmodule

`default_nettype wire
